@@ rtl/core/tcw_pkg.sv @@
// Shared constants, codes and types of the text console writer.
package tcw_pkg;

  // Screen and video memory geometry.
  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int VRAM_CELLS   = 8192;
  localparam int SCREEN_CELLS = COLUMNS * ROWS;
  // A scroll starting at or above this display start relocates the screen first.
  localparam int RELOC_START  = VRAM_CELLS - SCREEN_CELLS - COLUMNS;

  // Field widths.
  localparam int CELL_AW = 13;
  localparam int CELL_W  = 16;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CHAR_W  = 8;
  localparam int FUNC_W  = 2;

  localparam logic [CELL_AW-1:0] COLUMNS_CELLS = CELL_AW'(COLUMNS);
  localparam logic [CELL_AW-1:0] SCREEN_SPAN   = CELL_AW'(SCREEN_CELLS);
  localparam logic [CELL_W-1:0]  RESET_CELL    = CELL_W'(16'h0007);

  // Item functions.
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

  // Character codes with a control meaning.
  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_HT  = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;

  // Configuration register indexes.
  localparam logic CFG_CHAR_ATTR  = 1'b0;
  localparam logic CFG_BLANK_CELL = 1'b1;

  // Request to the shared address adder.
  typedef struct packed {
    logic [CELL_AW-1:0] a;
    logic [CELL_AW-1:0] b;
    logic               sub;
  } alu_req_t;

endpackage

@@ rtl/core/tcw_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/tcw_addr_alu.sv @@
// Shared cell address adder: adds or subtracts modulo the video memory size.
module tcw_addr_alu
  import tcw_pkg::*;
(
  input  alu_req_t           req,
  output logic [CELL_AW-1:0] y
);

  // Cell indexes are exactly CELL_AW bits, so the natural wrap is the modulo.
  assign y = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule

@@ rtl/core/text_console_writer_unit.sv @@
// Top level of the text console writer: sequencer, state registers and ports.
//
// The block keeps a text video memory of 8192 cells of 16 bits (character in
// the low byte, attribute in the high byte) together with a display start, a
// cursor cell, a column, a row and a committed hardware cursor. Each input
// transfer carries one item: put a character, read a cell, clear everything
// or do nothing; every item produces exactly one result transfer that shows
// the state after the item, and read_data holds the cell word for a read and
// zero otherwise. Work runs on a small sequencer that drives one shared 13-bit
// address adder and one write port plus one registered read port of the video
// RAM, so at most one memory write, one memory read and one address step
// happen per cycle. A line feed on the last row scrolls: the new row is
// erased, and when the display start is at or above RELOC_START the screen is
// first copied back to the memory base with one read and one write per cell.
// A clear writes the blank cell to every cell. After reset the block runs a
// clearing pass that sets all 8192 cells to 0x0007, with in_ready low
// meanwhile; configuration writes are taken at any time. The next input is
// taken as soon as the sequencer is idle, even while the last result still
// waits in the output register.
module text_console_writer_unit
  import tcw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Configuration
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CELL_W-1:0]  cfg_wdata,
  // Input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [CHAR_W-1:0]  in_ch,
  input  logic [CELL_AW-1:0] in_cell_addr,
  input  logic               in_end_of_write,
  // Result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CELL_AW-1:0] out_display_start,
  output logic [CELL_AW-1:0] out_hw_cursor,
  output logic [CELL_AW-1:0] out_cursor_cell,
  output logic [COL_W-1:0]   out_column,
  output logic [ROW_W-1:0]   out_row,
  output logic [CELL_W-1:0]  out_read_data
);

  // Sequencer states.
  localparam logic [4:0] S_INIT      = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_DECODE    = 5'd2;
  localparam logic [4:0] S_READ      = 5'd3;
  localparam logic [4:0] S_CLEAR     = 5'd4;
  localparam logic [4:0] S_LF        = 5'd5;
  localparam logic [4:0] S_COPY_RD   = 5'd6;
  localparam logic [4:0] S_COPY_WR   = 5'd7;
  localparam logic [4:0] S_COPY_FIX  = 5'd8;
  localparam logic [4:0] S_SCR_BASE  = 5'd9;
  localparam logic [4:0] S_SCR_ERASE = 5'd10;
  localparam logic [4:0] S_SCR_SS    = 5'd11;
  localparam logic [4:0] S_SCR_POS   = 5'd12;
  localparam logic [4:0] S_LF_END    = 5'd13;
  localparam logic [4:0] S_CR        = 5'd14;
  localparam logic [4:0] S_PRINT     = 5'd15;
  localparam logic [4:0] S_ERASE     = 5'd16;
  localparam logic [4:0] S_DONE      = 5'd17;

  // Control state.
  logic [4:0]         state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CELL_AW-1:0] ss_r, ss_nxt;
  logic [CELL_AW-1:0] pos_r, pos_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [CELL_AW-1:0] hwc_r, hwc_nxt;
  logic [CELL_AW-1:0] cnt_r, cnt_nxt;
  logic [CHAR_W-1:0]  attr_r, attr_nxt;
  logic [CELL_W-1:0]  blank_r, blank_nxt;
  logic               cr_after_r, cr_after_nxt;
  logic               print_after_r, print_after_nxt;

  // Payload registers.
  logic [FUNC_W-1:0]  func_r, func_nxt;
  logic [CHAR_W-1:0]  ch_r, ch_nxt;
  logic [CELL_AW-1:0] addr_r, addr_nxt;
  logic               eow_r, eow_nxt;
  logic [CELL_AW-1:0] ptr_r, ptr_nxt;
  logic [CELL_W-1:0]  rdata_r, rdata_nxt;
  logic [CELL_AW-1:0] o_ss_r, o_ss_nxt;
  logic [CELL_AW-1:0] o_hwc_r, o_hwc_nxt;
  logic [CELL_AW-1:0] o_pos_r, o_pos_nxt;
  logic [COL_W-1:0]   o_col_r, o_col_nxt;
  logic [ROW_W-1:0]   o_row_r, o_row_nxt;
  logic [CELL_W-1:0]  o_data_r, o_data_nxt;

  // Shared adder and video RAM ports.
  alu_req_t           alu_req;
  logic [CELL_AW-1:0] alu_y;
  logic               ram_we;
  logic [CELL_AW-1:0] ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [CELL_AW-1:0] ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;

  logic in_fire;
  logic commit;
  logic result_free;

  assign in_ready    = (state_r == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign result_free = !out_valid_r || out_ready;
  assign commit      = (func_r != FUNC_NOP) && eow_r;

  tcw_addr_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (VRAM_CELLS)
  ) u_vram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Operand selection for the shared adder; each state uses it at most once.
  always_comb begin
    alu_req.a   = pos_r;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;
    case (state_r)
      S_DECODE: begin
        alu_req.sub = 1'b1;
        // Backspace steps back one cell; a wrapped printable goes back a row.
        alu_req.b   = (ch_r == CH_BS) ? CELL_AW'(1) : COLUMNS_CELLS;
      end
      S_LF: begin
        alu_req.b = COLUMNS_CELLS;
      end
      S_COPY_RD, S_SCR_ERASE: begin
        alu_req.a = ptr_r;
        alu_req.b = CELL_AW'(1);
      end
      S_COPY_FIX: begin
        alu_req.b   = ss_r;
        alu_req.sub = 1'b1;
      end
      S_SCR_BASE: begin
        alu_req.a = ss_r;
        alu_req.b = SCREEN_SPAN;
      end
      S_SCR_SS: begin
        alu_req.a = ss_r;
        alu_req.b = COLUMNS_CELLS;
      end
      S_SCR_POS: begin
        alu_req.b = COLUMNS_CELLS;
      end
      S_CR: begin
        alu_req.b   = CELL_AW'(col_r);
        alu_req.sub = 1'b1;
      end
      S_PRINT: begin
        alu_req.b = CELL_AW'(1);
      end
      default: begin
        alu_req.a = pos_r;
      end
    endcase
  end

  // Video RAM port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = blank_r;
    ram_raddr = (state_r == S_COPY_RD) ? ptr_r : addr_r;
    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = RESET_CELL;
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
      end
      S_COPY_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = ram_rdata;
      end
      S_SCR_ERASE: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
      end
      S_PRINT: begin
        ram_we    = 1'b1;
        ram_wdata = {attr_r, ch_r};
      end
      S_ERASE: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    ss_nxt          = ss_r;
    pos_nxt         = pos_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    hwc_nxt         = hwc_r;
    cnt_nxt         = cnt_r;
    attr_nxt        = attr_r;
    blank_nxt       = blank_r;
    cr_after_nxt    = cr_after_r;
    print_after_nxt = print_after_r;
    func_nxt        = func_r;
    ch_nxt          = ch_r;
    addr_nxt        = addr_r;
    eow_nxt         = eow_r;
    ptr_nxt         = ptr_r;
    rdata_nxt       = rdata_r;
    o_ss_nxt        = o_ss_r;
    o_hwc_nxt       = o_hwc_r;
    o_pos_nxt       = o_pos_r;
    o_col_nxt       = o_col_r;
    o_row_nxt       = o_row_r;
    o_data_nxt      = o_data_r;

    // Configuration writes are accepted in any state.
    if (cfg_we) begin
      if (cfg_index == CFG_CHAR_ATTR) begin
        attr_nxt = cfg_wdata[CHAR_W-1:0];
      end else begin
        blank_nxt = cfg_wdata;
      end
    end

    case (state_r)
      S_INIT: begin
        cnt_nxt = cnt_r + CELL_AW'(1);
        if (cnt_r == CELL_AW'(VRAM_CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          func_nxt  = in_func;
          ch_nxt    = in_ch;
          addr_nxt  = in_cell_addr;
          eow_nxt   = in_end_of_write;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cr_after_nxt    = 1'b0;
        print_after_nxt = 1'b0;
        cnt_nxt         = '0;
        state_nxt       = S_DONE;
        case (func_r)
          FUNC_READ: begin
            state_nxt = S_READ;
          end
          FUNC_CLEAR: begin
            ss_nxt    = '0;
            pos_nxt   = '0;
            col_nxt   = '0;
            row_nxt   = '0;
            hwc_nxt   = '0;
            state_nxt = S_CLEAR;
          end
          FUNC_PUT: begin
            case (ch_r)
              CH_NUL, CH_BEL, CH_HT, CH_VT: begin
                state_nxt = S_DONE;
              end
              CH_BS: begin
                if (col_r != '0) begin
                  col_nxt   = col_r - COL_W'(1);
                  pos_nxt   = alu_y;
                  state_nxt = S_ERASE;
                end
              end
              CH_LF: begin
                cr_after_nxt = 1'b1;
                state_nxt    = S_LF;
              end
              CH_FF: begin
                state_nxt = S_LF;
              end
              CH_CR: begin
                state_nxt = S_CR;
              end
              CH_DEL: begin
                state_nxt = S_ERASE;
              end
              default: begin
                // At the line end the cursor first returns to the row start
                // and a line feed follows before the character is written.
                if (col_r >= COL_W'(COLUMNS)) begin
                  col_nxt         = col_r - COL_W'(COLUMNS);
                  pos_nxt         = alu_y;
                  print_after_nxt = 1'b1;
                  state_nxt       = S_LF;
                end else begin
                  state_nxt = S_PRINT;
                end
              end
            endcase
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_READ: begin
        rdata_nxt = ram_rdata;
        state_nxt = S_DONE;
      end
      S_CLEAR: begin
        cnt_nxt = cnt_r + CELL_AW'(1);
        if (cnt_r == CELL_AW'(VRAM_CELLS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_LF: begin
        cnt_nxt = '0;
        if (row_r < ROW_W'(ROWS - 1)) begin
          row_nxt   = row_r + ROW_W'(1);
          pos_nxt   = alu_y;
          state_nxt = S_LF_END;
        end else if (ss_r >= CELL_AW'(RELOC_START)) begin
          // Too close to the memory end: move the screen back to the base.
          ptr_nxt   = ss_r;
          state_nxt = S_COPY_RD;
        end else begin
          state_nxt = S_SCR_BASE;
        end
      end
      S_COPY_RD: begin
        ptr_nxt   = alu_y;
        state_nxt = S_COPY_WR;
      end
      S_COPY_WR: begin
        cnt_nxt = cnt_r + CELL_AW'(1);
        if (cnt_r == CELL_AW'(SCREEN_CELLS - 1)) begin
          state_nxt = S_COPY_FIX;
        end else begin
          state_nxt = S_COPY_RD;
        end
      end
      S_COPY_FIX: begin
        pos_nxt   = alu_y;
        ss_nxt    = '0;
        state_nxt = S_SCR_BASE;
      end
      S_SCR_BASE: begin
        cnt_nxt   = '0;
        ptr_nxt   = alu_y;
        state_nxt = S_SCR_ERASE;
      end
      S_SCR_ERASE: begin
        ptr_nxt = alu_y;
        cnt_nxt = cnt_r + CELL_AW'(1);
        if (cnt_r == CELL_AW'(COLUMNS - 1)) begin
          state_nxt = S_SCR_SS;
        end
      end
      S_SCR_SS: begin
        ss_nxt    = alu_y;
        state_nxt = S_SCR_POS;
      end
      S_SCR_POS: begin
        pos_nxt   = alu_y;
        state_nxt = S_LF_END;
      end
      S_LF_END: begin
        if (cr_after_r) begin
          state_nxt = S_CR;
        end else if (print_after_r) begin
          state_nxt = S_PRINT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CR: begin
        pos_nxt   = alu_y;
        col_nxt   = '0;
        state_nxt = S_DONE;
      end
      S_PRINT: begin
        pos_nxt   = alu_y;
        col_nxt   = col_r + COL_W'(1);
        state_nxt = S_DONE;
      end
      S_ERASE: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hold the finished item until the output register is free.
        if (result_free) begin
          if (commit) begin
            hwc_nxt = pos_r;
          end
          o_ss_nxt      = ss_r;
          o_hwc_nxt     = commit ? pos_r : hwc_r;
          o_pos_nxt     = pos_r;
          o_col_nxt     = col_r;
          o_row_nxt     = row_r;
          o_data_nxt    = (func_r == FUNC_READ) ? rdata_r : '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_INIT;
      out_valid_r   <= 1'b0;
      ss_r          <= '0;
      pos_r         <= '0;
      col_r         <= '0;
      row_r         <= '0;
      hwc_r         <= '0;
      cnt_r         <= '0;
      attr_r        <= CHAR_W'(8'h07);
      blank_r       <= RESET_CELL;
      cr_after_r    <= 1'b0;
      print_after_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      ss_r          <= ss_nxt;
      pos_r         <= pos_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      hwc_r         <= hwc_nxt;
      cnt_r         <= cnt_nxt;
      attr_r        <= attr_nxt;
      blank_r       <= blank_nxt;
      cr_after_r    <= cr_after_nxt;
      print_after_r <= print_after_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    ch_r     <= ch_nxt;
    addr_r   <= addr_nxt;
    eow_r    <= eow_nxt;
    ptr_r    <= ptr_nxt;
    rdata_r  <= rdata_nxt;
    o_ss_r   <= o_ss_nxt;
    o_hwc_r  <= o_hwc_nxt;
    o_pos_r  <= o_pos_nxt;
    o_col_r  <= o_col_nxt;
    o_row_r  <= o_row_nxt;
    o_data_r <= o_data_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_display_start = o_ss_r;
  assign out_hw_cursor     = o_hwc_r;
  assign out_cursor_cell   = o_pos_r;
  assign out_column        = o_col_r;
  assign out_row           = o_row_r;
  assign out_read_data     = o_data_r;

`ifndef ASSERT_OFF
  // A result only appears when the sequencer has finished an item.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the finishing step");

  // The cursor column never exceeds COLUMNS and the row stays below ROWS.
  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= COL_W'(COLUMNS)) && (row_r < ROW_W'(ROWS)))
    else $error("cursor column or row out of range");

  // No item is taken while the memory clearing pass after reset runs.
  a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |=> !$past(in_fire))
    else $error("input accepted during reset clearing pass");
`endif

endmodule
